// File: rtl/edm_pkg.sv
// Package: shared widths, constants and register codes of the echo distance median block.
`timescale 1ns / 1ps

package edm_pkg;

  localparam int unsigned EchoW    = 15;
  localparam int unsigned DistW    = 10;
  localparam int unsigned FactorW  = 12;
  localparam int unsigned SamplesW = 4;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW    = EchoW + FactorW;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  localparam logic [SamplesW-1:0] SamplesRst = SamplesW'(5);
  localparam logic [DistW-1:0]    ErrDistRst = DistW'(999);
  localparam logic [FactorW-1:0]  FactorRst  = FactorW'(1124);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSamples = 2'd0,
    CfgErrDist = 2'd1,
    CfgFactor  = 2'd2,
    CfgUnused  = 2'd3
  } cfg_idx_e;

endpackage

// File: rtl/edm_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module edm_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: rtl/echo_distance_median_top.sv
// Top level: echo duration to distance conversion, batch store and rank-count median.
//
//   channel   direction  handshake                fields
//   in        input      in_valid_i / in_stall_o  echo_us_i
//   out       output     out_valid_o / out_stall_i median_cm_o
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An item that does not close a batch is written to the store.
// An item that closes a batch of n starts a rank scan over the store RAM, in which the single
// RAM port reads every entry once per candidate.
// in_stall_o is high during the scan and while a finished median waits for the output slot.
// Reset clears the batch count, the output slot and loads the register defaults.
`timescale 1ns / 1ps

module echo_distance_median_top #(
  parameter int unsigned MAX_SAMPLES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [edm_pkg::EchoW-1:0]   echo_us_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [edm_pkg::DistW-1:0]   median_cm_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [edm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [edm_pkg::FactorW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IdxW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned NW   = (CntW > edm_pkg::SamplesW) ? CntW : edm_pkg::SamplesW;
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_SAMPLES);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_SAMPLES - 1);
  localparam logic [NW-1:0]   MaxN    = NW'(MAX_SAMPLES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CAND  = 3'd1;
  localparam logic [2:0] S_CLOAD = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [edm_pkg::SamplesW-1:0] samples_q;
  logic [edm_pkg::DistW-1:0]    err_dist_q;
  logic [edm_pkg::FactorW-1:0]  factor_q;

  logic [2:0]                 state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            n_q, n_d;
  logic [CntW-1:0]            i_q, i_d;
  logic [CntW-1:0]            j_q, j_d;
  logic [CntW-1:0]            rank_q, rank_d;
  logic [edm_pkg::DistW-1:0]  cand_q, cand_d;
  logic [edm_pkg::DistW-1:0]  hi_q, hi_d;
  logic [edm_pkg::DistW-1:0]  lo_q, lo_d;
  logic                       found_q, found_d;
  logic                       out_valid_q, out_valid_d;
  logic [edm_pkg::DistW-1:0]  median_q, median_d;

  logic                       in_acc;
  logic [NW-1:0]              n_len;
  logic [CntW-1:0]            slot;
  logic [CntW-1:0]            count_new;
  logic [edm_pkg::ProdW-1:0]  prod;
  logic [edm_pkg::DistW-1:0]  sample_cm;
  logic                       ram_we;
  logic [CntW-1:0]            ram_addr;
  logic [edm_pkg::DistW-1:0]  ram_rdata;
  logic                       hit;
  logic [CntW-1:0]            rank_fin;
  logic [CntW-1:0]            k_hi;
  logic [CntW-1:0]            k_lo;
  logic [edm_pkg::DistW:0]    pair_sum;
  logic                       out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign median_cm_o = median_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q  <= edm_pkg::SamplesRst;
      err_dist_q <= edm_pkg::ErrDistRst;
      factor_q   <= edm_pkg::FactorRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        edm_pkg::CfgSamples: samples_q  <= cfg_data_i[edm_pkg::SamplesW-1:0];
        edm_pkg::CfgErrDist: err_dist_q <= cfg_data_i[edm_pkg::DistW-1:0];
        edm_pkg::CfgFactor:  factor_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // batch length: zero acts as one, clamp to store depth
  always_comb begin
    n_len = NW'(samples_q);
    if (n_len == '0) begin
      n_len = NW'(1);
    end else if (n_len > MaxN) begin
      n_len = MaxN;
    end
  end

  assign slot      = (count_q >= MaxCnt) ? LastCnt : count_q;
  assign count_new = CntW'(slot + 1'b1);

  assign prod = edm_pkg::ProdW'(echo_us_i) * edm_pkg::ProdW'(factor_q);
  always_comb begin
    if (echo_us_i == '0) begin
      sample_cm = err_dist_q;
    end else if (prod[edm_pkg::ProdW-1:edm_pkg::FracBits] >
                 (edm_pkg::ProdW - edm_pkg::FracBits)'(edm_pkg::DistMax)) begin
      sample_cm = edm_pkg::DistMax;
    end else begin
      sample_cm = prod[edm_pkg::FracBits +: edm_pkg::DistW];
    end
  end

  // stable rank: smaller values, plus equal values at lower index
  assign hit      = (ram_rdata < cand_q) || ((ram_rdata == cand_q) && (j_q < i_q));
  assign rank_fin = CntW'(rank_q + CntW'(hit));
  assign k_hi     = n_q >> 1;
  assign k_lo     = CntW'(k_hi - 1'b1);
  assign pair_sum = (edm_pkg::DistW + 1)'(hi_q) + (edm_pkg::DistW + 1)'(lo_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    rank_d      = rank_q;
    cand_d      = cand_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    found_d     = found_q;
    median_d    = median_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_addr    = slot;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ram_we = 1'b1;
          if (NW'(count_new) >= n_len) begin
            count_d = '0;
            n_d     = n_len[CntW-1:0];
            i_d     = '0;
            found_d = 1'b0;
            state_d = S_CAND;
          end else begin
            count_d = count_new;
          end
        end
      end
      S_CAND: begin
        ram_addr = i_q;
        state_d  = S_CLOAD;
      end
      S_CLOAD: begin
        ram_addr = '0;
        cand_d   = ram_rdata;
        j_d      = '0;
        rank_d   = '0;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        ram_addr = CntW'(j_q + 1'b1);
        rank_d   = rank_fin;
        j_d      = CntW'(j_q + 1'b1);
        if (CntW'(j_q + 1'b1) == n_q) begin
          if (rank_fin == k_hi) begin
            hi_d    = cand_q;
            found_d = 1'b1;
          end
          if (rank_fin == k_lo) begin
            lo_d = cand_q;
          end
          i_d = CntW'(i_q + 1'b1);
          state_d = (CntW'(i_q + 1'b1) == n_q) ? S_FIN : S_CAND;
        end
      end
      S_FIN: begin
        if (out_free) begin
          median_d    = n_q[0] ? hi_q : pair_sum[edm_pkg::DistW:1];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  edm_ram #(
    .Width (edm_pkg::DistW),
    .Depth (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr[IdxW-1:0]),
    .wdata_i (sample_cm),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    i_q      <= i_d;
    j_q      <= j_d;
    rank_q   <= rank_d;
    cand_q   <= cand_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    median_q <= median_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("batch count beyond store depth");

  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("median presented outside finish step");

  a_median_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> found_q)
    else $error("no entry ranked at the middle");

  a_batch_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && (state_d == S_CAND) |=> count_q == '0)
    else $error("batch count not cleared on close");

endmodule

// File: bench/edm_median_checker.sv
// Checker: predicts the batch medians from observed transactions and compares the results.
`timescale 1ns / 1ps

module edm_median_checker
  import edm_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [EchoW-1:0]    echo_us_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [DistW-1:0]    median_cm_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [FactorW-1:0]  cfg_data_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  logic [SamplesW-1:0] samples_q;
  logic [DistW-1:0]    err_dist_q;
  logic [FactorW-1:0]  factor_q;
  logic [DistW-1:0]    sample_store [MAX_SAMPLES];
  int unsigned         fill_count;
  logic [DistW-1:0]    pending_medians [$];

  function automatic logic [DistW-1:0] echo_to_distance(input logic [EchoW-1:0] echo);
    logic [ProdW-1:0] product;
    logic [ProdW-1:0] scaled;
    if (echo == '0) return err_dist_q;
    product = echo * factor_q;
    scaled  = product >> FracBits;
    return (scaled > ProdW'(DistMax)) ? DistMax : scaled[DistW-1:0];
  endfunction

  function automatic logic [DistW-1:0] batch_median(input int unsigned n);
    logic [DistW-1:0] sorted [MAX_SAMPLES];
    logic [DistW-1:0] v;
    int               j;
    for (int i = 0; i < n; i++) sorted[i] = sample_store[i];
    for (int i = 1; i < n; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (n % 2 == 1) return sorted[n/2];
    return DistW'((int'(sorted[n/2]) + int'(sorted[n/2-1])) / 2);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned      n;
    int unsigned      slot;
    logic [DistW-1:0] want;
    if (!rst_ni) begin
      samples_q    = SamplesRst;
      err_dist_q   = ErrDistRst;
      factor_q     = FactorRst;
      fill_count   = 0;
      pending_medians.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgSamples: samples_q  = cfg_data_i[SamplesW-1:0];
          CfgErrDist: err_dist_q = cfg_data_i[DistW-1:0];
          CfgFactor:  factor_q   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_medians.size() == 0) begin
          report_mismatch($sformatf("median_cm %0d with no transaction expected", median_cm_i));
        end else begin
          want = pending_medians.pop_front();
          if (median_cm_i !== want)
            report_mismatch($sformatf("median_cm %0d, expected %0d", median_cm_i, want));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // zero length acts as one, oversize lengths clamp to the store depth
        n = (samples_q == 0) ? 1 : (samples_q > MAX_SAMPLES) ? MAX_SAMPLES : samples_q;
        slot = (fill_count >= MAX_SAMPLES) ? MAX_SAMPLES - 1 : fill_count;
        sample_store[slot] = echo_to_distance(echo_us_i);
        fill_count = slot + 1;
        if (fill_count >= n) begin
          pending_medians.push_back(batch_median(n));
          fill_count = 0;
        end
      end
      pending_o = pending_medians.size();
    end
  end

endmodule

// File: bench/echo_distance_median_top_tb.sv
// Testbench top: drives echo and register transactions into the median block and reports the verdict.
`timescale 1ns / 1ps

module echo_distance_median_top_tb;
  import edm_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned RandomItems = 750;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [EchoW-1:0]    echo_us_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DistW-1:0]    median_cm_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [FactorW-1:0]  cfg_data_i;
  int                  mismatches;
  int                  pending;
  bit                  idle_on;
  int unsigned         cycle_count = 0;

  always #10 clk_i = ~clk_i;

  echo_distance_median_top #(.MAX_SAMPLES(8)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .echo_us_i,
    .out_valid_o, .out_stall_i, .median_cm_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  edm_median_checker #(.MAX_SAMPLES(8)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .echo_us_i,
    .out_valid_i(out_valid_o), .out_stall_i, .median_cm_i(median_cm_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("echo_distance_median_top test failed");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_echo(input logic [EchoW-1:0] echo);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    echo_us_i  <= echo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [FactorW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for every expected median, then let a partial batch write settle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // result side: random stall per result, plus random stall pulses while idle
  initial begin
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o === 1'b1) begin
        hold = idle_on ? $urandom_range(0, 5) : 0;
        out_stall_i <= (hold > 0);
        if (hold > 0) begin
          repeat (hold) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
        @(posedge clk_i);
        while (!(out_valid_o && !out_stall_i)) @(posedge clk_i);
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 7) == 0);
      end
    end
  end

  initial begin
    int unsigned          random_sent;
    int unsigned          burst;
    logic [EchoW-1:0]     echo;
    logic [SamplesW-1:0]  nib;
    logic [7:0]           hi;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    echo_us_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgSamples;
    cfg_data_i  = '0;
    idle_on     = 1'b1;
    random_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset defaults: batches of five, timeout and out-of-range echoes
    send_echo(0);
    send_echo(1);
    send_echo(30000);
    send_echo(30001);
    send_echo(15'h7FFF);
    settle();

    // zero length acts as one, full factor saturates the distance
    write_register(CfgSamples, 0);
    write_register(CfgFactor, 4095);
    write_register(CfgErrDist, 0);
    send_echo(0);
    send_echo(15'h7FFF);
    send_echo(16384);
    send_echo(1);
    settle();

    // oversize length clamps to eight
    write_register(CfgSamples, 15);
    write_register(CfgErrDist, 1023);
    write_register(CfgUnused, 12'hFFF);
    send_echo(0);
    send_echo(15'h7FFF);
    send_echo(15'h5555);
    send_echo(15'h2AAA);
    send_echo(1);
    send_echo(100);
    send_echo(20000);
    send_echo(30000);
    settle();

    // even length takes the floored mean, zero factor
    write_register(CfgSamples, 2);
    write_register(CfgFactor, 0);
    send_echo(123);
    send_echo(0);
    settle();

    // length lowered while a batch is half full
    write_register(CfgSamples, 8);
    write_register(CfgFactor, FactorRst);
    send_echo(5000);
    send_echo(200);
    send_echo(0);
    send_echo(9000);
    send_echo(700);
    settle();
    write_register(CfgSamples, 3);
    send_echo(12000);

    while (random_sent < RandomItems) begin
      settle();
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0: nib = 0;
          1: nib = 1;
          2: nib = 8;
          3: nib = 4'($urandom_range(9, 15));
          default: nib = 4'($urandom_range(2, 7));
        endcase
        hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : '0;
        write_register(CfgSamples, {hi, nib});
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0: write_register(CfgErrDist, 0);
          1: write_register(CfgErrDist, 1023);
          default: write_register(CfgErrDist, 12'($urandom_range(0, 4095)));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0: write_register(CfgFactor, 0);
          1: write_register(CfgFactor, 4095);
          2: write_register(CfgFactor, FactorRst);
          default: write_register(CfgFactor, 12'($urandom_range(0, 4095)));
        endcase
      end
      if ($urandom_range(0, 7) == 0) write_register(CfgUnused, 12'($urandom_range(0, 4095)));
      idle_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(8, 48);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0: echo = '0;
          1: echo = 15'h7FFF;
          2: echo = 15'($urandom_range(29990, 30010));
          3: echo = 15'($urandom_range(1, 64));
          default: echo = 15'($urandom_range(0, 32767));
        endcase
        send_echo(echo);
        random_sent++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("echo_distance_median_top test passed");
    end else begin
      $display("echo_distance_median_top test failed");
    end
    $finish;
  end

endmodule
